FILE: src/e2c_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// e2c_pkg: shared types and constants for the epoch to calendar converter
// Holds the controller states, the command and status words between the
// controller and the datapath, the result word and the calendar constants.
// ----------------------------------------------------------------------------
package e2c_pkg;

  localparam logic [31:0] SECS_TO_2000 = 32'd946684800;
  localparam logic [31:0] SECS_TO_2100 = 32'd4102444800;

  localparam logic [6:0] DIV_60 = 7'd60;
  localparam logic [6:0] DIV_24 = 7'd24;

  // Reciprocals: n / 60 = (n * RECIP_60) >> 37 for any 32-bit n, while
  // n / 24 and n / 7 are (n * RECIP) >> 32 for the day and hour counts.
  localparam logic [31:0] RECIP_60 = 32'h8888_8889;
  localparam logic [31:0] RECIP_24 = 32'h0AAA_AAAB;
  localparam logic [31:0] RECIP_7  = 32'h2492_4925;

  localparam logic [15:0] DAYS_PER_QUAD = 16'd1461;
  localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
  localparam logic [2:0]  DAYS_PER_WEEK = 3'd7;
  localparam logic [2:0]  WEEKDAY_BIAS  = 3'd6;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEC_MUL,
    ST_SEC,
    ST_MIN_MUL,
    ST_MIN,
    ST_HOUR_MUL,
    ST_HOUR,
    ST_WEEK_MUL,
    ST_WEEK,
    ST_QUAD,
    ST_YEAR,
    ST_MONTH,
    ST_FINISH
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_60,
    OP_MUL_24,
    OP_MUL_7,
    OP_SEC,
    OP_MIN,
    OP_HOUR,
    OP_WEEK,
    OP_QUAD,
    OP_YEAR,
    OP_YEAR_END,
    OP_MONTH,
    OP_OUT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic oor;
    logic quad_ge;
    logic year_ge;
    logic month_ge;
  } status_t;

  typedef struct packed {
    logic [5:0] sec_out;
    logic [5:0] min_out;
    logic [4:0] hour_out;
    logic [2:0] weekday;
    logic [4:0] day_of_month;
    logic [3:0] month_out;
    logic [6:0] year_offset;
    logic [8:0] day_of_year;
    logic       out_of_range;
  } result_t;

  function automatic logic [4:0] month_len(input logic [3:0] month);
    logic [4:0] len;
    case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      4'd2: len = 5'd28;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage
`default_nettype wire

FILE: src/e2c_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// e2c_if: handshake channels of the epoch to calendar converter
// The timestamp channel carries one epoch word, the result channel one
// calendar word; each word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface e2c_stamp_if;
  logic        valid;
  logic        ready;
  logic [31:0] epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink (input valid, input epoch_seconds, output ready);
endinterface

interface e2c_result_if;
  logic       valid;
  logic       ready;
  logic [5:0] sec_out;
  logic [5:0] min_out;
  logic [4:0] hour_out;
  logic [2:0] weekday;
  logic [4:0] day_of_month;
  logic [3:0] month_out;
  logic [6:0] year_offset;
  logic [8:0] day_of_year;
  logic       out_of_range;

  modport source (
    output valid, output sec_out, output min_out, output hour_out, output weekday,
    output day_of_month, output month_out, output year_offset, output day_of_year,
    output out_of_range, input ready
  );
  modport sink (
    input valid, input sec_out, input min_out, input hour_out, input weekday,
    input day_of_month, input month_out, input year_offset, input day_of_year,
    input out_of_range, output ready
  );
endinterface
`default_nettype wire

FILE: src/e2c_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// e2c_datapath: arithmetic and storage of the epoch to calendar converter
// A shared reciprocal multiplier for the divisions by 60, 24 and 7, a year
// and month walker and the registered result word, all stepped by the
// controller's commands.
// ----------------------------------------------------------------------------
module e2c_datapath (
  input  wire logic            clk,
  input  wire e2c_pkg::cmd_t   cmd,
  input  wire logic [31:0]     epoch_seconds,
  output e2c_pkg::status_t     status,
  output e2c_pkg::result_t     result
);

  logic [31:0] num;
  logic [63:0] prod;
  logic [5:0]  sec;
  logic [5:0]  min;
  logic [4:0]  hour;
  logic [2:0]  wday;
  logic [15:0] days;
  logic [6:0]  year;
  logic [8:0]  doy;
  logic [3:0]  month;
  logic        oor;

  logic [31:0] recip;
  logic [31:0] quo;
  logic [6:0]  divisor;
  logic [31:0] rem;
  logic [3:0]  wbias;
  logic [2:0]  wday_next;
  logic        leap;
  logic [8:0]  year_len;
  logic [4:0]  mlen;

  always_comb begin
    case (cmd.op)
      e2c_pkg::OP_MUL_24: begin
        recip = e2c_pkg::RECIP_24;
      end
      e2c_pkg::OP_MUL_7: begin
        recip = e2c_pkg::RECIP_7;
      end
      default: begin
        recip = e2c_pkg::RECIP_60;
      end
    endcase
    case (cmd.op)
      e2c_pkg::OP_HOUR: begin
        quo     = prod[63:32];
        divisor = e2c_pkg::DIV_24;
      end
      e2c_pkg::OP_WEEK: begin
        quo     = prod[63:32];
        divisor = {4'd0, e2c_pkg::DAYS_PER_WEEK};
      end
      default: begin
        quo     = {5'd0, prod[63:37]};
        divisor = e2c_pkg::DIV_60;
      end
    endcase
    rem       = num - quo * {25'd0, divisor};
    wbias     = {1'b0, rem[2:0]} + {1'b0, e2c_pkg::WEEKDAY_BIAS};
    wday_next = (wbias >= {1'b0, e2c_pkg::DAYS_PER_WEEK}) ?
                3'(wbias - {1'b0, e2c_pkg::DAYS_PER_WEEK}) : wbias[2:0];
    leap      = (year[1:0] == 2'd0);
    year_len  = e2c_pkg::DAYS_PER_YEAR + {8'd0, leap};
    mlen      = e2c_pkg::month_len(month) +
                {4'd0, (leap && (month == e2c_pkg::MONTH_FEB))};
  end

  always_comb begin
    status.oor      = oor;
    status.quad_ge  = (days >= e2c_pkg::DAYS_PER_QUAD);
    status.year_ge  = (days >= {7'd0, year_len});
    status.month_ge = (month != e2c_pkg::MONTH_DEC) && (days >= {11'd0, mlen});
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      e2c_pkg::OP_LOAD: begin
        oor   <= (epoch_seconds < e2c_pkg::SECS_TO_2000) ||
                 (epoch_seconds >= e2c_pkg::SECS_TO_2100);
        num   <= epoch_seconds - e2c_pkg::SECS_TO_2000;
        year  <= 7'd0;
        month <= e2c_pkg::MONTH_JAN;
      end
      e2c_pkg::OP_MUL_60, e2c_pkg::OP_MUL_24, e2c_pkg::OP_MUL_7: begin
        prod <= {32'd0, num} * {32'd0, recip};
      end
      e2c_pkg::OP_SEC: begin
        sec <= rem[5:0];
        num <= quo;
      end
      e2c_pkg::OP_MIN: begin
        min <= rem[5:0];
        num <= quo;
      end
      e2c_pkg::OP_HOUR: begin
        hour <= rem[4:0];
        num  <= quo;
        days <= quo[15:0];
      end
      e2c_pkg::OP_WEEK: begin
        wday <= wday_next;
      end
      e2c_pkg::OP_QUAD: begin
        days <= days - e2c_pkg::DAYS_PER_QUAD;
        year <= year + 7'd4;
      end
      e2c_pkg::OP_YEAR: begin
        days <= days - {7'd0, year_len};
        year <= year + 7'd1;
      end
      e2c_pkg::OP_YEAR_END: begin
        doy <= days[8:0];
      end
      e2c_pkg::OP_MONTH: begin
        days  <= days - {11'd0, mlen};
        month <= month + 4'd1;
      end
      e2c_pkg::OP_OUT: begin
        if (oor) begin
          result.sec_out      <= 6'd0;
          result.min_out      <= 6'd0;
          result.hour_out     <= 5'd0;
          result.weekday      <= 3'd0;
          result.day_of_month <= 5'd0;
          result.month_out    <= 4'd0;
          result.year_offset  <= 7'd0;
          result.day_of_year  <= 9'd0;
          result.out_of_range <= 1'b1;
        end else begin
          result.sec_out      <= sec;
          result.min_out      <= min;
          result.hour_out     <= hour;
          result.weekday      <= wday;
          result.day_of_month <= days[4:0] + 5'd1;
          result.month_out    <= month;
          result.year_offset  <= year;
          result.day_of_year  <= doy + 9'd1;
          result.out_of_range <= 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: src/e2c_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// e2c_ctrl: sequencer of the epoch to calendar converter
// Steps the datapath through the four divisions, the year walk and the
// month walk, and owns the handshake of both channels.
// ----------------------------------------------------------------------------
module e2c_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  input  wire e2c_pkg::status_t status,
  output e2c_pkg::cmd_t         cmd
);

  e2c_pkg::state_t state;
  e2c_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= e2c_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.op == e2c_pkg::OP_OUT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = e2c_pkg::OP_NONE;
    in_ready   = 1'b0;
    case (state)
      e2c_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = e2c_pkg::OP_LOAD;
          state_next = e2c_pkg::ST_SEC_MUL;
        end
      end
      e2c_pkg::ST_SEC_MUL: begin
        if (status.oor) begin
          state_next = e2c_pkg::ST_FINISH;
        end else begin
          cmd.op     = e2c_pkg::OP_MUL_60;
          state_next = e2c_pkg::ST_SEC;
        end
      end
      e2c_pkg::ST_SEC: begin
        cmd.op     = e2c_pkg::OP_SEC;
        state_next = e2c_pkg::ST_MIN_MUL;
      end
      e2c_pkg::ST_MIN_MUL: begin
        cmd.op     = e2c_pkg::OP_MUL_60;
        state_next = e2c_pkg::ST_MIN;
      end
      e2c_pkg::ST_MIN: begin
        cmd.op     = e2c_pkg::OP_MIN;
        state_next = e2c_pkg::ST_HOUR_MUL;
      end
      e2c_pkg::ST_HOUR_MUL: begin
        cmd.op     = e2c_pkg::OP_MUL_24;
        state_next = e2c_pkg::ST_HOUR;
      end
      e2c_pkg::ST_HOUR: begin
        cmd.op     = e2c_pkg::OP_HOUR;
        state_next = e2c_pkg::ST_WEEK_MUL;
      end
      e2c_pkg::ST_WEEK_MUL: begin
        cmd.op     = e2c_pkg::OP_MUL_7;
        state_next = e2c_pkg::ST_WEEK;
      end
      e2c_pkg::ST_WEEK: begin
        cmd.op     = e2c_pkg::OP_WEEK;
        state_next = e2c_pkg::ST_QUAD;
      end
      e2c_pkg::ST_QUAD: begin
        if (status.quad_ge) begin
          cmd.op = e2c_pkg::OP_QUAD;
        end else begin
          state_next = e2c_pkg::ST_YEAR;
        end
      end
      e2c_pkg::ST_YEAR: begin
        if (status.year_ge) begin
          cmd.op = e2c_pkg::OP_YEAR;
        end else begin
          cmd.op     = e2c_pkg::OP_YEAR_END;
          state_next = e2c_pkg::ST_MONTH;
        end
      end
      e2c_pkg::ST_MONTH: begin
        if (status.month_ge) begin
          cmd.op = e2c_pkg::OP_MONTH;
        end else begin
          state_next = e2c_pkg::ST_FINISH;
        end
      end
      e2c_pkg::ST_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.op     = e2c_pkg::OP_OUT;
          state_next = e2c_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = e2c_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: src/epoch_to_calendar.sv
`default_nettype none
// ----------------------------------------------------------------------------
// epoch_to_calendar: Unix timestamp to calendar date and time of day
// Converts one 32-bit epoch word into second, minute, hour, weekday, day of
// month, month, year since 2000 and day of year.
// ----------------------------------------------------------------------------
// One word is converted at a time. A word in 2000..2099 is converted in
// steps: the four divisions by 60, 60, 24 and 7 on a shared reciprocal
// multiplier (a multiply step and a split step each), up to 24 four-year
// steps and 3 single-year steps of the year walk, up to 11 month steps, a
// step to close each of the three walks and one to write the result. A word
// outside that span skips the divisions and walks and gives its result with
// out_of_range set and all other fields zero. The result sits in an output
// register and the next word can be taken in the cycle after it is written,
// even while that result still waits to be read; a result that is not read
// holds the following one back.
// ----------------------------------------------------------------------------
module epoch_to_calendar (
  input  wire logic   clk,
  input  wire logic   rst,
  e2c_stamp_if.sink   stamp,
  e2c_result_if.source result
);

  e2c_pkg::cmd_t    cmd;
  e2c_pkg::status_t status;
  e2c_pkg::result_t res_word;

  e2c_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (stamp.valid),
    .in_ready  (stamp.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .status    (status),
    .cmd       (cmd)
  );

  e2c_datapath u_datapath (
    .clk           (clk),
    .cmd           (cmd),
    .epoch_seconds (stamp.epoch_seconds),
    .status        (status),
    .result        (res_word)
  );

  assign result.sec_out      = res_word.sec_out;
  assign result.min_out      = res_word.min_out;
  assign result.hour_out     = res_word.hour_out;
  assign result.weekday      = res_word.weekday;
  assign result.day_of_month = res_word.day_of_month;
  assign result.month_out    = res_word.month_out;
  assign result.year_offset  = res_word.year_offset;
  assign result.day_of_year  = res_word.day_of_year;
  assign result.out_of_range = res_word.out_of_range;

endmodule
`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the epoch to calendar converter
// Epoch words are sent through the timestamp channel while a calendar
// predictor computes the expected date and time for every accepted word.
// Each word on the result channel is compared field by field, in order. The
// run covers both range limits, month and year edges, leap days, random
// stamps across the whole 32-bit span, output back-pressure and source pauses.
// ----------------------------------------------------------------------------
module tb;

  typedef struct {
    logic [31:0]      stamp_val;
    e2c_pkg::result_t cal;
  } expected_date_t;

  logic clk = 1'b0;
  logic rst;

  e2c_stamp_if  stamp ();
  e2c_result_if result ();

  epoch_to_calendar u_top (
    .clk    (clk),
    .rst    (rst),
    .stamp  (stamp),
    .result (result)
  );

  expected_date_t pending_dates[$];
  int mismatch_count;
  bit src_idle_on;
  bit sink_idle_on;
  int hold_left;
  int stall_left;

  always #6 clk = ~clk;

  function automatic int month_days(input int yr, input int mon);
    int len;
    case (mon)
      2: begin
        len = (yr % 4 == 0) ? 29 : 28;
      end
      4, 6, 9, 11: begin
        len = 30;
      end
      default: begin
        len = 31;
      end
    endcase
    return len;
  endfunction

  function automatic e2c_pkg::result_t calendar_of(input logic [31:0] stamp_val);
    e2c_pkg::result_t r;
    longint t;
    int days;
    int yr;
    int mon;
    int year_len;
    r = '0;
    if (stamp_val < e2c_pkg::SECS_TO_2000 || stamp_val >= e2c_pkg::SECS_TO_2100) begin
      r.out_of_range = 1'b1;
      return r;
    end
    t = longint'(stamp_val) - longint'(e2c_pkg::SECS_TO_2000);
    r.sec_out = 6'(t % 60);
    t = t / 60;
    r.min_out = 6'(t % 60);
    t = t / 60;
    r.hour_out = 5'(t % 24);
    days = int'(t / 24);
    r.weekday = 3'((days + 6) % 7);
    yr = 0;
    year_len = 366;
    while (days >= year_len) begin
      days -= year_len;
      yr++;
      year_len = (yr % 4 == 0) ? 366 : 365;
    end
    r.year_offset = 7'(yr);
    r.day_of_year = 9'(days + 1);
    mon = 1;
    while (mon < 12 && days >= month_days(yr, mon)) begin
      days -= month_days(yr, mon);
      mon++;
    end
    r.month_out = 4'(mon);
    r.day_of_month = 5'(days + 1);
    return r;
  endfunction

  function automatic logic [31:0] stamp_of(input int yr, input int mon, input int day,
                                           input int h, input int m, input int s);
    longint days;
    int y;
    int mo;
    days = 0;
    for (y = 0; y < yr; y++) days += (y % 4 == 0) ? 366 : 365;
    for (mo = 1; mo < mon; mo++) days += month_days(yr, mo);
    days += day - 1;
    return 32'(longint'(e2c_pkg::SECS_TO_2000) + days * 86400 + h * 3600 + m * 60 + s);
  endfunction

  function automatic logic [31:0] random_stamp();
    int yr;
    int mon;
    int day;
    int kind;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      if ($urandom_range(0, 1) == 0) return $urandom_range(0, e2c_pkg::SECS_TO_2000 - 1);
      return $urandom_range(e2c_pkg::SECS_TO_2100, 32'hFFFF_FFFF);
    end
    if (kind <= 3) begin
      yr = $urandom_range(0, 99);
      mon = $urandom_range(1, 12);
      case ($urandom_range(0, 2))
        0: day = 1;
        1: day = month_days(yr, mon);
        default: day = $urandom_range(1, month_days(yr, mon));
      endcase
      if ($urandom_range(0, 1) == 0) return stamp_of(yr, mon, day, 23, 59, 59);
      return stamp_of(yr, mon, day, $urandom_range(0, 23), $urandom_range(0, 59),
                      $urandom_range(0, 59));
    end
    return $urandom_range(e2c_pkg::SECS_TO_2000, e2c_pkg::SECS_TO_2100 - 1);
  endfunction

  task automatic send_stamp(input logic [31:0] stamp_val);
    int gap;
    gap = 0;
    if (src_idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 12);
    @(negedge clk);
    if (gap > 0) begin
      stamp.valid <= 1'b0;
      stamp.epoch_seconds <= $urandom;
      repeat (gap) @(negedge clk);
    end
    stamp.valid <= 1'b1;
    stamp.epoch_seconds <= stamp_val;
    @(posedge clk);
    while (!stamp.ready) @(posedge clk);
    pending_dates.push_back('{stamp_val: stamp_val, cal: calendar_of(stamp_val)});
  endtask

  task automatic stop_sending();
    @(negedge clk);
    stamp.valid <= 1'b0;
  endtask

  task automatic drain_results();
    stop_sending();
    while (pending_dates.size() > 0) @(posedge clk);
  endtask

  function automatic void check_field(input string name, input logic [31:0] stamp_val,
                                      input int want, input int got);
    if (want != got) begin
      if (mismatch_count < 10) begin
        $display("mismatch on %s for epoch %0d: expected %0d, got %0d",
                 name, stamp_val, want, got);
      end
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    expected_date_t want;
    if (!rst && result.valid && result.ready) begin
      if (pending_dates.size() == 0) begin
        if (mismatch_count < 10) $display("result word at %0t with none expected", $time);
        mismatch_count++;
      end else begin
        want = pending_dates.pop_front();
        check_field("sec_out", want.stamp_val, want.cal.sec_out, result.sec_out);
        check_field("min_out", want.stamp_val, want.cal.min_out, result.min_out);
        check_field("hour_out", want.stamp_val, want.cal.hour_out, result.hour_out);
        check_field("weekday", want.stamp_val, want.cal.weekday, result.weekday);
        check_field("day_of_month", want.stamp_val, want.cal.day_of_month,
                    result.day_of_month);
        check_field("month_out", want.stamp_val, want.cal.month_out, result.month_out);
        check_field("year_offset", want.stamp_val, want.cal.year_offset, result.year_offset);
        check_field("day_of_year", want.stamp_val, want.cal.day_of_year, result.day_of_year);
        check_field("out_of_range", want.stamp_val, want.cal.out_of_range,
                    result.out_of_range);
      end
    end
  end

  initial begin
    result.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        result.ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        result.ready <= 1'b0;
        stall_left--;
      end else if (sink_idle_on && $urandom_range(0, 9) == 0) begin
        result.ready <= 1'b0;
        stall_left = $urandom_range(0, 11);
      end else begin
        result.ready <= 1'b1;
      end
    end
  end

  task automatic test_directed();
    send_stamp(32'h0000_0000);
    send_stamp(32'hFFFF_FFFF);
    send_stamp(e2c_pkg::SECS_TO_2000 - 1);
    send_stamp(e2c_pkg::SECS_TO_2000);
    send_stamp(e2c_pkg::SECS_TO_2100 - 1);
    send_stamp(e2c_pkg::SECS_TO_2100);
    send_stamp(stamp_of(0, 2, 28, 23, 59, 59));
    send_stamp(stamp_of(0, 2, 29, 12, 0, 0));
    send_stamp(stamp_of(0, 3, 1, 0, 0, 0));
    send_stamp(stamp_of(0, 12, 31, 23, 59, 59));
    send_stamp(stamp_of(1, 1, 1, 0, 0, 0));
    send_stamp(stamp_of(1, 2, 28, 6, 30, 15));
    send_stamp(stamp_of(1, 3, 1, 0, 0, 0));
    send_stamp(stamp_of(3, 12, 31, 23, 59, 59));
    send_stamp(stamp_of(4, 2, 29, 0, 0, 1));
    send_stamp(stamp_of(38, 1, 19, 3, 14, 7));
    send_stamp(stamp_of(50, 7, 4, 18, 45, 30));
    send_stamp(stamp_of(96, 2, 29, 11, 11, 11));
    send_stamp(stamp_of(99, 1, 1, 0, 0, 0));
    send_stamp(stamp_of(99, 12, 31, 23, 59, 59));
    send_stamp(32'h7FFF_FFFF);
    send_stamp(32'h8000_0000);
    send_stamp(32'hAAAA_AAAA);
    send_stamp(32'h5555_5555);
  endtask

  task automatic test_random();
    int seg;
    for (seg = 0; seg < 8; seg++) begin
      src_idle_on = ($urandom_range(0, 3) != 0);
      sink_idle_on = ($urandom_range(0, 3) != 0);
      repeat (110) send_stamp(random_stamp());
    end
  endtask

  task automatic test_output_stall();
    src_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    @(posedge clk);
    hold_left = 300;
    repeat (12) send_stamp(random_stamp());
  endtask

  task automatic test_sender_pause();
    src_idle_on = 1'b1;
    sink_idle_on = 1'b1;
    repeat (3) begin
      repeat (5) send_stamp(random_stamp());
      drain_results();
    end
  endtask

  task automatic test_steady_stream();
    src_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    repeat (120) send_stamp(random_stamp());
  endtask

  initial begin
    rst = 1'b1;
    stamp.valid = 1'b0;
    stamp.epoch_seconds = '0;
    src_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    hold_left = 0;
    stall_left = 0;
    mismatch_count = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random();
    test_output_stall();
    test_sender_pause();
    test_steady_stream();
    drain_results();
    repeat (200) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
